// ===== design/csht_pkg.sv =====
// shared codes, command and status types for the chained scatter hash table
`timescale 1ns / 1ps

package csht_pkg;

    localparam int KEY_W      = 30;
    localparam int VAL_PORT_W = 32;
    localparam int START_W    = 7;
    localparam int SLOT_OUT_W = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADKEY = 2'd3;

    typedef enum logic [1:0] {
        A_E,
        A_MP,
        A_FP
    } addr_sel_t;

    typedef enum logic [3:0] {
        W_NONE,
        W_SWEEP,
        W_DEL,
        W_SETV,
        W_INS_HOME,
        W_P_LINK,
        W_F_MOVED,
        W_MP_NEW,
        W_F_NEW,
        W_MP_LINKF
    } wr_t;

    typedef enum logic [3:0] {
        U_NONE,
        U_CLEAR,
        U_E_START,
        U_E_INC,
        U_FIND_INIT,
        U_FOLLOW,
        U_SAVE_MP,
        U_FP_DEC,
        U_F_SET,
        U_P_INIT
    } uop_t;

    typedef enum logic [3:0] {
        R_BADKEY,
        R_MISS,
        R_FULL,
        R_CLEAR,
        R_HIT_READ,
        R_HIT_SET,
        R_INS_MP,
        R_INS_F,
        R_SCAN
    } res_t;

    typedef struct packed {
        logic      load;
        logic      rd_en;
        addr_sel_t rd_sel;
        wr_t       wr;
        uop_t      uop;
        logic      mod_start;
        logic      mod_sel;    // 0 input key, 1 displaced resident key
        logic      res_load;
        res_t      res;
    } csht_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad_key;
        logic            start_oob;
        logic            mod_done;
        logic            key_match;
        logic            key_zero;
        logic            link_zero;
        logic            link_bad;
        logic            link_is_mp;
        logic            steps_last;
        logic            steps_full;
        logic            e_last;
        logic            fp_zero;
        logic            home_is_mp;
        logic            out_busy;
    } csht_stat_t;

endpackage

// ===== design/csht_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module csht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/csht_mod.sv =====
// key modulo table size: low bits for a power of two, else reciprocal multiply and correct
`timescale 1ns / 1ps

module csht_mod
    import csht_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [KEY_W-1:0]         operand,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] result
);

    localparam int IDX_W = $clog2(SLOTS);

    generate
        if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
            logic             done_reg;
            logic [IDX_W-1:0] res_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    res_reg <= operand[IDX_W-1:0];
                end
            end

            assign done   = done_reg;
            assign result = res_reg;
        end else begin : g_recip
            // floor(2^KEY_W / SLOTS): the quotient estimate is low by at most one
            localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / SLOTS);

            logic [1:0]         vld_reg;
            logic               done_reg;
            logic [KEY_W-1:0]   opnd_reg;
            logic [2*KEY_W-1:0] prod_reg;
            logic [KEY_W-1:0]   qm_reg;
            logic [IDX_W-1:0]   rem_reg;
            logic [KEY_W-1:0]   diff;
            logic [KEY_W-1:0]   rem_full;

            // remainder estimate lies below twice the table size
            assign diff     = opnd_reg - qm_reg;
            assign rem_full = (diff >= KEY_W'(SLOTS)) ? diff - KEY_W'(SLOTS) : diff;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg  <= '0;
                    done_reg <= 1'b0;
                end else begin
                    vld_reg  <= {vld_reg[0], start};
                    done_reg <= vld_reg[1];
                end
                if (start) begin
                    opnd_reg <= operand;
                    prod_reg <= (2*KEY_W)'(operand) * (2*KEY_W)'(RECIP);
                end
                if (vld_reg[0]) begin
                    qm_reg <= prod_reg[2*KEY_W-1:KEY_W] * KEY_W'(SLOTS);
                end
                if (vld_reg[1]) begin
                    rem_reg <= rem_full[IDX_W-1:0];
                end
            end

            assign done   = done_reg;
            assign result = rem_reg;
        end
    endgenerate

endmodule

// ===== design/csht_dp.sv =====
// datapath: slot memories, walk registers, free pointer, counters and result register
`timescale 1ns / 1ps

module csht_dp
    import csht_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [OP_W-1:0]       in_op,
    input  logic [KEY_W-1:0]      in_key,
    input  logic [VAL_PORT_W-1:0] in_value,
    input  logic [START_W-1:0]    in_start,
    input  csht_cmd_t             cmd,
    output csht_stat_t            stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,
    output logic [7:0]            m_tuser
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int KL_W   = KEY_W + LINK_W;
    localparam int VW     = VALUE_BITS;

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VW-1:0]      val_reg;
    logic [START_W-1:0] start_reg;

    logic [IDX_W-1:0]   e_reg;
    logic [IDX_W-1:0]   mp_reg;
    logic [IDX_W-1:0]   f_reg;
    logic [LINK_W-1:0]  fp_reg;
    logic [LINK_W-1:0]  cnt_reg;
    logic [LINK_W-1:0]  steps_reg;
    logic [KEY_W-1:0]   rkm_reg;
    logic [LINK_W-1:0]  rlm_reg;
    logic [VW-1:0]      rvm_reg;

    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]    res_slot_reg;
    logic [KEY_W-1:0]    res_key_reg;
    logic [VW-1:0]       res_val_reg;
    logic [LINK_W-1:0]   res_cnt_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [IDX_W-1:0]    res_slot_next;
    logic [KEY_W-1:0]    res_key_next;
    logic [VW-1:0]       res_val_next;

    logic              kl_we;
    logic [IDX_W-1:0]  kl_waddr;
    logic [KL_W-1:0]   kl_wdata;
    logic [KL_W-1:0]   kl_rdata;
    logic              v_we;
    logic [IDX_W-1:0]  v_waddr;
    logic [VW-1:0]     v_wdata;
    logic [VW-1:0]     rd_val;
    logic [IDX_W-1:0]  raddr;

    logic [KEY_W-1:0]  rd_key;
    logic [LINK_W-1:0] rd_link;
    logic [IDX_W-1:0]  link_idx;
    logic [LINK_W-1:0] f_link;
    logic              cnt_inc;
    logic              cnt_dec;

    logic              mod_done;
    logic [IDX_W-1:0]  home;

    logic [VW+VAL_PORT_W-1:0]   vin_ext;
    logic [VW+VAL_PORT_W-1:0]   vout_ext;
    logic [IDX_W+START_W-1:0]   start_ext;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
    logic [LINK_W+CNT_OUT_W-1:0] cnt_ext;

    assign vin_ext   = {{VW{1'b0}}, in_value};
    assign start_ext = {{IDX_W{1'b0}}, start_reg};

    assign rd_key   = kl_rdata[KL_W-1:LINK_W];
    assign rd_link  = kl_rdata[LINK_W-1:0];
    assign link_idx = IDX_W'(rd_link - LINK_W'(1));
    assign f_link   = LINK_W'(f_reg) + LINK_W'(1);

    csht_ram #(.WIDTH(KL_W), .DEPTH(SLOTS)) u_kl_ram (
        .aclk  (aclk),
        .we    (kl_we),
        .waddr (kl_waddr),
        .wdata (kl_wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (kl_rdata)
    );

    csht_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_val_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rd_val)
    );

    csht_mod #(.SLOTS(SLOTS)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .operand (cmd.mod_sel ? rkm_reg : key_reg),
        .done    (mod_done),
        .result  (home)
    );

    always_comb begin
        unique case (cmd.rd_sel)
            A_MP:    raddr = mp_reg;
            A_FP:    raddr = fp_reg[IDX_W-1:0];
            default: raddr = e_reg;
        endcase
    end

    always_comb begin
        kl_we    = 1'b0;
        kl_waddr = e_reg;
        kl_wdata = '0;
        v_we     = 1'b0;
        v_waddr  = e_reg;
        v_wdata  = val_reg;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        unique case (cmd.wr)
            W_SWEEP: begin
                kl_we = 1'b1;
            end
            W_DEL: begin
                // key goes, link stays so the chain through this slot survives
                kl_we    = 1'b1;
                kl_wdata = {{KEY_W{1'b0}}, rd_link};
                cnt_dec  = (cnt_reg != '0);
            end
            W_SETV: begin
                v_we = 1'b1;
            end
            W_INS_HOME: begin
                kl_we    = 1'b1;
                kl_waddr = mp_reg;
                kl_wdata = {key_reg, rd_link};
                v_we     = 1'b1;
                v_waddr  = mp_reg;
                cnt_inc  = 1'b1;
            end
            W_P_LINK: begin
                kl_we    = 1'b1;
                kl_wdata = {rd_key, f_link};
            end
            W_F_MOVED: begin
                kl_we    = 1'b1;
                kl_waddr = f_reg;
                kl_wdata = {rkm_reg, rlm_reg};
                v_we     = 1'b1;
                v_waddr  = f_reg;
                v_wdata  = rvm_reg;
            end
            W_MP_NEW: begin
                kl_we    = 1'b1;
                kl_waddr = mp_reg;
                kl_wdata = {key_reg, {LINK_W{1'b0}}};
                v_we     = 1'b1;
                v_waddr  = mp_reg;
                cnt_inc  = 1'b1;
            end
            W_F_NEW: begin
                kl_we    = 1'b1;
                kl_waddr = f_reg;
                kl_wdata = {key_reg, rlm_reg};
                v_we     = 1'b1;
                v_waddr  = f_reg;
            end
            W_MP_LINKF: begin
                kl_we    = 1'b1;
                kl_waddr = mp_reg;
                kl_wdata = {rkm_reg, f_link};
                cnt_inc  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_status_next = ST_OK;
        res_slot_next   = '0;
        res_key_next    = '0;
        res_val_next    = '0;
        unique case (cmd.res)
            R_BADKEY: res_status_next = ST_BADKEY;
            R_MISS:   res_status_next = ST_MISS;
            R_FULL:   res_status_next = ST_FULL;
            R_HIT_READ: begin
                res_slot_next = e_reg;
                res_key_next  = key_reg;
                res_val_next  = rd_val;
            end
            R_HIT_SET: begin
                res_slot_next = e_reg;
                res_key_next  = key_reg;
                res_val_next  = val_reg;
            end
            R_INS_MP: begin
                res_slot_next = mp_reg;
                res_key_next  = key_reg;
                res_val_next  = val_reg;
            end
            R_INS_F: begin
                res_slot_next = f_reg;
                res_key_next  = key_reg;
                res_val_next  = val_reg;
            end
            R_SCAN: begin
                res_slot_next = e_reg;
                res_key_next  = rd_key;
                res_val_next  = rd_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            val_reg   <= vin_ext[VW-1:0];
            start_reg <= in_start;
        end
        if (!aresetn) begin
            e_reg         <= '0;
            fp_reg        <= LINK_W'(SLOTS);
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            unique case (cmd.uop)
                U_CLEAR: begin
                    e_reg  <= '0;
                    fp_reg <= LINK_W'(SLOTS);
                end
                U_E_START:   e_reg <= start_ext[IDX_W-1:0];
                U_E_INC:     e_reg <= e_reg + IDX_W'(1);
                U_FIND_INIT: begin
                    e_reg     <= home;
                    mp_reg    <= home;
                    steps_reg <= '0;
                end
                U_FOLLOW: begin
                    e_reg     <= link_idx;
                    steps_reg <= steps_reg + LINK_W'(1);
                end
                U_SAVE_MP: begin
                    rkm_reg <= rd_key;
                    rlm_reg <= rd_link;
                    rvm_reg <= rd_val;
                end
                U_FP_DEC: fp_reg <= fp_reg - LINK_W'(1);
                U_F_SET:  f_reg <= fp_reg[IDX_W-1:0];
                U_P_INIT: begin
                    e_reg     <= home;
                    steps_reg <= '0;
                end
                default: begin
                end
            endcase
            if (cmd.uop == U_CLEAR) begin
                cnt_reg <= '0;
            end else if (cnt_inc) begin
                cnt_reg <= cnt_reg + LINK_W'(1);
            end else if (cnt_dec) begin
                cnt_reg <= cnt_reg - LINK_W'(1);
            end
            if (cmd.res_load) begin
                res_valid_reg <= 1'b1;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
        end
        if (cmd.res_load) begin
            res_cnt_reg    <= cnt_reg;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_key_reg    <= res_key_next;
            res_val_reg    <= res_val_next;
        end
    end

    always_comb begin
        stat            = '0;
        stat.op         = op_reg;
        stat.bad_key    = (key_reg == '0);
        stat.start_oob  = ({{LINK_W{1'b0}}, start_reg} >= (LINK_W+START_W)'(SLOTS));
        stat.mod_done   = mod_done;
        stat.key_match  = (rd_key == key_reg);
        stat.key_zero   = (rd_key == '0);
        stat.link_zero  = (rd_link == '0);
        stat.link_bad   = (rd_link == '0) || (rd_link > LINK_W'(SLOTS));
        stat.link_is_mp = (link_idx == mp_reg);
        stat.steps_last = (steps_reg == LINK_W'(SLOTS - 1));
        stat.steps_full = (steps_reg == LINK_W'(SLOTS));
        stat.e_last     = (e_reg == IDX_W'(SLOTS - 1));
        stat.fp_zero    = (fp_reg == '0);
        stat.home_is_mp = (home == mp_reg);
        stat.out_busy   = res_valid_reg && !m_tready;
    end

    assign vout_ext = {{VAL_PORT_W{1'b0}}, res_val_reg};
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_reg};
    assign cnt_ext  = {{CNT_OUT_W{1'b0}}, res_cnt_reg};

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {5'b0, cnt_ext[CNT_OUT_W-1:0], vout_ext[VAL_PORT_W-1:0],
                       res_key_reg, slot_ext[SLOT_OUT_W-1:0]};
    assign m_tuser  = {6'b0, res_status_reg};

endmodule

// ===== design/csht_ctrl.sv =====
// controller: sequences lookups, chain walks, free-slot search, relocation and clear
`timescale 1ns / 1ps

module csht_ctrl
    import csht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  csht_stat_t stat,
    output csht_cmd_t  cmd
);

    typedef enum logic [4:0] {
        SWEEP,
        IDLE,
        DECODE,
        HOME_WAIT,
        FIND_RD,
        FIND_CHK,
        INS_RD,
        INS_CHK,
        FREE_DEC,
        FREE_RD,
        FREE_CHK,
        OTHER_WAIT,
        MP_LINKF,
        P_RD,
        P_CHK,
        MOVE_F,
        MOVE_MP,
        SCAN_RD,
        SCAN_CHK,
        DONE
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   clr_reg, clr_next;

    assign s_tready = (state_reg == IDLE);

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        clr_next      = clr_reg;
        cmd           = '0;
        cmd.rd_sel    = A_E;
        cmd.wr        = W_NONE;
        cmd.uop       = U_NONE;
        cmd.res       = R_MISS;
        cmd.load      = s_tvalid && s_tready;
        unique case (state_reg)
            SWEEP: begin
                cmd.wr = W_SWEEP;
                if (stat.e_last) begin
                    if (clr_reg) begin
                        res_next   = R_CLEAR;
                        state_next = DONE;
                    end else begin
                        state_next = IDLE;
                    end
                end else begin
                    cmd.uop = U_E_INC;
                end
            end
            IDLE: begin
                if (s_tvalid) begin
                    state_next = DECODE;
                end
            end
            DECODE: begin
                priority if (stat.op > OP_CLEAR) begin
                    res_next   = R_MISS;
                    state_next = DONE;
                end else if (stat.op <= OP_DELETE && stat.bad_key) begin
                    res_next   = R_BADKEY;
                    state_next = DONE;
                end else if (stat.op == OP_CLEAR) begin
                    cmd.uop    = U_CLEAR;
                    clr_next   = 1'b1;
                    state_next = SWEEP;
                end else if (stat.op == OP_SCAN) begin
                    if (stat.start_oob) begin
                        res_next   = R_MISS;
                        state_next = DONE;
                    end else begin
                        cmd.uop    = U_E_START;
                        state_next = SCAN_RD;
                    end
                end else begin
                    cmd.mod_start = 1'b1;
                    state_next    = HOME_WAIT;
                end
            end
            HOME_WAIT: begin
                if (stat.mod_done) begin
                    cmd.uop    = U_FIND_INIT;
                    state_next = FIND_RD;
                end
            end
            FIND_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = FIND_CHK;
            end
            FIND_CHK: begin
                priority if (stat.key_match) begin
                    state_next = DONE;
                    if (stat.op == OP_SET) begin
                        cmd.wr   = W_SETV;
                        res_next = R_HIT_SET;
                    end else begin
                        if (stat.op == OP_DELETE) begin
                            cmd.wr = W_DEL;
                        end
                        res_next = R_HIT_READ;
                    end
                end else if (stat.link_bad || stat.steps_last) begin
                    if (stat.op == OP_SET) begin
                        state_next = INS_RD;
                    end else begin
                        res_next   = R_MISS;
                        state_next = DONE;
                    end
                end else begin
                    cmd.uop    = U_FOLLOW;
                    state_next = FIND_RD;
                end
            end
            INS_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = A_MP;
                state_next = INS_CHK;
            end
            INS_CHK: begin
                if (stat.key_zero) begin
                    cmd.wr     = W_INS_HOME;
                    res_next   = R_INS_MP;
                    state_next = DONE;
                end else begin
                    cmd.uop    = U_SAVE_MP;
                    state_next = FREE_DEC;
                end
            end
            FREE_DEC: begin
                if (stat.fp_zero) begin
                    res_next   = R_FULL;
                    state_next = DONE;
                end else begin
                    cmd.uop    = U_FP_DEC;
                    state_next = FREE_RD;
                end
            end
            FREE_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = A_FP;
                state_next = FREE_CHK;
            end
            FREE_CHK: begin
                if (stat.key_zero && stat.link_zero) begin
                    cmd.uop       = U_F_SET;
                    cmd.mod_start = 1'b1;
                    cmd.mod_sel   = 1'b1;
                    state_next    = OTHER_WAIT;
                end else begin
                    state_next = FREE_DEC;
                end
            end
            OTHER_WAIT: begin
                if (stat.mod_done) begin
                    if (stat.home_is_mp) begin
                        // resident is at home: splice new key in after it
                        cmd.wr     = W_F_NEW;
                        state_next = MP_LINKF;
                    end else begin
                        cmd.uop    = U_P_INIT;
                        state_next = P_RD;
                    end
                end
            end
            MP_LINKF: begin
                cmd.wr     = W_MP_LINKF;
                res_next   = R_INS_F;
                state_next = DONE;
            end
            P_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = P_CHK;
            end
            P_CHK: begin
                // find the predecessor of the home slot in the resident's chain
                if (stat.steps_full || stat.link_bad || stat.link_is_mp) begin
                    cmd.wr     = W_P_LINK;
                    state_next = MOVE_F;
                end else begin
                    cmd.uop    = U_FOLLOW;
                    state_next = P_RD;
                end
            end
            MOVE_F: begin
                cmd.wr     = W_F_MOVED;
                state_next = MOVE_MP;
            end
            MOVE_MP: begin
                cmd.wr     = W_MP_NEW;
                res_next   = R_INS_MP;
                state_next = DONE;
            end
            SCAN_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = SCAN_CHK;
            end
            SCAN_CHK: begin
                priority if (!stat.key_zero) begin
                    res_next   = R_SCAN;
                    state_next = DONE;
                end else if (stat.e_last) begin
                    res_next   = R_MISS;
                    state_next = DONE;
                end else begin
                    cmd.uop    = U_E_INC;
                    state_next = SCAN_RD;
                end
            end
            DONE: begin
                if (!stat.out_busy) begin
                    cmd.res_load = 1'b1;
                    cmd.res      = res_reg;
                    clr_next     = 1'b0;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SWEEP;
            res_reg   <= R_MISS;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            clr_reg   <= clr_next;
        end
    end

endmodule

// ===== design/chained_scatter_hash_table.sv =====
// top level of the chained scatter hash table
`timescale 1ns / 1ps
// Hash table of SLOTS entries keyed by nonzero 30-bit keys, collisions resolved
// by chaining with relocation of entries that sit outside their home slot.
// Input words carry an operation (lookup, set, delete, scan, clear) in s_tuser
// and key, value and scan start in s_tdata. Each word yields one result word
// with status in m_tuser and slot, key, value and live count in m_tdata.
// One word is in work at a time; s_tready is high only while the block is idle.
// After accept the home slot is computed, then each chain slot is read and
// checked in turn. A set of a new key also reads the home slot; if it is taken,
// the free pointer steps down to a free slot, the home of the resident is found,
// then the new key is spliced in, or the resident's chain is walked and it moves.
// Scan examines slots from the start slot upward. The home slot comes from the
// low key bits when SLOTS is a power of two, else the reciprocal remainder unit.
// Each step reads the slot memories through their single read port.
// The next word can be taken in the cycle after the result is loaded.
// After reset, and on a clear, the key/link memory is swept with s_tready low.
// The result register lets the next word be taken while a result waits; if the
// receiver stalls, the following result waits until the one before is taken.

module chained_scatter_hash_table
    import csht_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key[29:0], value_in[61:30], start_slot[68:62]
    input  logic [7:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // slot[5:0], found_key[35:6], value_out[67:36],
                                   // live_count[74:68]
    output logic [7:0]  m_tuser    // status[1:0]
);

    csht_cmd_t  cmd;
    csht_stat_t stat;

    csht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csht_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_op    (s_tuser[OP_W-1:0]),
        .in_key   (s_tdata[29:0]),
        .in_value (s_tdata[61:30]),
        .in_start (s_tdata[68:62]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
